[rtl/cpc_pkg.sv]
// Package for the closest point on cylinder unit: widths, latency and word types.
// Used by every module in the rtl folder; it depends on nothing else.

package cpc_pkg;

  localparam int COORD_W   = 32;
  localparam int REG_W     = COORD_W - 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W;
  localparam int QUO_W     = REG_W;
  localparam int NUM_W     = 2 * REG_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int DIST_W    = SQ_W + 2;
  localparam int CFG_IDX_W = 1;
  localparam int LATENCY   = 9 + (ROOT_W + 1) + (QUO_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SURF_SIDE   = 2'd0,
    SURF_TOP    = 2'd1,
    SURF_BOTTOM = 2'd2
  } surf_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_z;
    surf_e                     surface;
  } proj_t;

  typedef struct packed {
    point_t           pt;
    logic [SQ_W-1:0]  s;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } sqrt_side_t;

  typedef struct packed {
    point_t          pt;
    logic [SQ_W-1:0] s;
  } div_side_t;

endpackage

[rtl/cpc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on cpc_pkg for widths and the sideband word type.

module cpc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [cpc_pkg::SQ_W-1:0]    s_i,
  input  cpc_pkg::sqrt_side_t         side_i,
  output logic                        valid_o,
  output logic [cpc_pkg::ROOT_W-1:0]  root_o,
  output cpc_pkg::sqrt_side_t         side_o
);

  typedef logic [cpc_pkg::SQ_W+1:0] trial_t;

  logic                        vld_q  [cpc_pkg::ROOT_W+1];
  logic [cpc_pkg::SQ_W-1:0]    rem_q  [cpc_pkg::ROOT_W+1];
  logic [cpc_pkg::ROOT_W-1:0]  res_q  [cpc_pkg::ROOT_W+1];
  cpc_pkg::sqrt_side_t         side_q [cpc_pkg::ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= s_i;
    res_q[0]  <= '0;
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < cpc_pkg::ROOT_W; i++) begin : g_stage
    localparam int B = cpc_pkg::ROOT_W - 1 - i;
    trial_t trial;
    logic   take;

    assign trial = (trial_t'(res_q[i]) << (B + 1)) + (trial_t'(1) << (2 * B));
    assign take  = trial_t'(rem_q[i]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= take ? rem_q[i] - trial[cpc_pkg::SQ_W-1:0] : rem_q[i];
      res_q[i+1]  <= take ? (res_q[i] | (cpc_pkg::ROOT_W'(1) << B)) : res_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[cpc_pkg::ROOT_W];
  assign root_o  = res_q[cpc_pkg::ROOT_W];
  assign side_o  = side_q[cpc_pkg::ROOT_W];

endmodule

[rtl/cpc_div.sv]
// Pipelined restoring divider: two dividends over one shared divisor, one quotient
// bit per register stage. Depends on cpc_pkg for widths and the sideband word type.

module cpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [cpc_pkg::ROOT_W-1:0]  root_i,
  input  logic [cpc_pkg::NUM_W-1:0]   num_x_i,
  input  logic [cpc_pkg::NUM_W-1:0]   num_y_i,
  input  cpc_pkg::div_side_t          side_i,
  output logic                        valid_o,
  output logic [cpc_pkg::QUO_W-1:0]   quo_x_o,
  output logic [cpc_pkg::QUO_W-1:0]   quo_y_o,
  output cpc_pkg::div_side_t          side_o
);

  typedef logic [cpc_pkg::ROOT_W:0] part_t;

  logic                        vld_q  [cpc_pkg::QUO_W+1];
  logic [cpc_pkg::ROOT_W-1:0]  den_q  [cpc_pkg::QUO_W+1];
  part_t                       px_q   [cpc_pkg::QUO_W+1];
  part_t                       py_q   [cpc_pkg::QUO_W+1];
  logic [cpc_pkg::QUO_W-1:0]   lox_q  [cpc_pkg::QUO_W+1];
  logic [cpc_pkg::QUO_W-1:0]   loy_q  [cpc_pkg::QUO_W+1];
  logic [cpc_pkg::QUO_W-1:0]   qx_q   [cpc_pkg::QUO_W+1];
  logic [cpc_pkg::QUO_W-1:0]   qy_q   [cpc_pkg::QUO_W+1];
  cpc_pkg::div_side_t          side_q [cpc_pkg::QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0]  <= root_i;
    px_q[0]   <= part_t'(num_x_i[cpc_pkg::NUM_W-1:cpc_pkg::QUO_W]);
    py_q[0]   <= part_t'(num_y_i[cpc_pkg::NUM_W-1:cpc_pkg::QUO_W]);
    lox_q[0]  <= num_x_i[cpc_pkg::QUO_W-1:0];
    loy_q[0]  <= num_y_i[cpc_pkg::QUO_W-1:0];
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < cpc_pkg::QUO_W; i++) begin : g_stage
    localparam int B = cpc_pkg::QUO_W - 1 - i;
    part_t nx, ny, dd;
    logic  gx, gy;

    assign dd = part_t'(den_q[i]);
    assign nx = {px_q[i][cpc_pkg::ROOT_W-1:0], lox_q[i][B]};
    assign ny = {py_q[i][cpc_pkg::ROOT_W-1:0], loy_q[i][B]};
    assign gx = nx >= dd;
    assign gy = ny >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[i+1]  <= den_q[i];
      px_q[i+1]   <= gx ? nx - dd : nx;
      py_q[i+1]   <= gy ? ny - dd : ny;
      lox_q[i+1]  <= lox_q[i];
      loy_q[i+1]  <= loy_q[i];
      qx_q[i+1]   <= {qx_q[i][cpc_pkg::QUO_W-2:0], gx};
      qy_q[i+1]   <= {qy_q[i][cpc_pkg::QUO_W-2:0], gy};
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[cpc_pkg::QUO_W];
  assign quo_x_o = qx_q[cpc_pkg::QUO_W];
  assign quo_y_o = qy_q[cpc_pkg::QUO_W];
  assign side_o  = side_q[cpc_pkg::QUO_W];

endmodule

[rtl/closest_point_on_cylinder_unit.sv]
// Top level: projects a Q20.12 point onto a capped cylinder on the z axis.
// Depends on cpc_pkg, cpc_sqrt and cpc_div.
//
//   channel   ports                                  moves
//   in        start_i, busy_o, point_i               one point word
//   out       done_o, result_o                       one projection word
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i       radius or height
//
// A new point may enter in every cycle; busy_o stays low.
// Each result passes through the 33-stage square root and the 32-stage
// divider in series plus nine arithmetic stages.
// Reset clears the valid bits and config registers only; no result is held back.

module closest_point_on_cylinder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  cpc_pkg::point_t                point_i,
  output logic                           done_o,
  output cpc_pkg::proj_t                 result_o,
  input  logic                           cfg_we_i,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpc_pkg::REG_W-1:0]      cfg_wdata_i
);

  typedef logic signed [cpc_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [cpc_pkg::DIFF_W-1:0]  diff_t;
  typedef logic [cpc_pkg::COORD_W-1:0]        mag_t;
  typedef logic [cpc_pkg::SQ_W-1:0]           sq_t;
  typedef logic [cpc_pkg::DIST_W-1:0]         dist_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t cx;
    coord_t cy;
    coord_t hz;
  } cand_t;

  function automatic mag_t mag_of(input diff_t d);
    diff_t n;
    n = -d;
    mag_of = d[cpc_pkg::DIFF_W-1] ? n[cpc_pkg::COORD_W-1:0] : d[cpc_pkg::COORD_W-1:0];
  endfunction

  function automatic coord_t apply_sign(input logic neg, input logic [cpc_pkg::QUO_W-1:0] q);
    coord_t v;
    v = coord_t'(q);
    apply_sign = neg ? -v : v;
  endfunction

  logic [cpc_pkg::REG_W-1:0]   cyl_radius_q, cyl_height_q;
  logic [cpc_pkg::SQ_W-1:0]    rad_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyl_radius_q <= '0;
      cyl_height_q <= '0;
      rad_sq_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cpc_pkg::CFG_RADIUS: cyl_radius_q <= cfg_wdata_i;
          cpc_pkg::CFG_HEIGHT: cyl_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      rad_sq_q <= sq_t'(cyl_radius_q) * sq_t'(cyl_radius_q);
    end
  end

  coord_t half;
  assign half = coord_t'(cyl_height_q[cpc_pkg::REG_W-1:1]);

  // Front stages: input register, magnitudes, products, sum of squares.
  logic                         v0_q, v1_q, v2_q, v3_q;
  cpc_pkg::point_t              pt0_q, pt1_q, pt2_q, pt3_q;
  mag_t                         ax1_q, ay1_q;
  sq_t                          sqx2_q, sqy2_q, s3_q;
  logic [cpc_pkg::NUM_W-1:0]    nx2_q, ny2_q, nx3_q, ny3_q;
  logic [cpc_pkg::NUM_W:0]      nx2_d, ny2_d;

  assign nx2_d = (cpc_pkg::NUM_W+1)'(ax1_q) * (cpc_pkg::NUM_W+1)'(cyl_radius_q);
  assign ny2_d = (cpc_pkg::NUM_W+1)'(ay1_q) * (cpc_pkg::NUM_W+1)'(cyl_radius_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pt0_q  <= point_i;
    pt1_q  <= pt0_q;
    ax1_q  <= mag_of(diff_t'(pt0_q.point_x));
    ay1_q  <= mag_of(diff_t'(pt0_q.point_y));
    pt2_q  <= pt1_q;
    sqx2_q <= sq_t'(ax1_q) * sq_t'(ax1_q);
    sqy2_q <= sq_t'(ay1_q) * sq_t'(ay1_q);
    nx2_q  <= nx2_d[cpc_pkg::NUM_W-1:0];
    ny2_q  <= ny2_d[cpc_pkg::NUM_W-1:0];
    pt3_q  <= pt2_q;
    s3_q   <= sqx2_q + sqy2_q;
    nx3_q  <= nx2_q;
    ny3_q  <= ny2_q;
  end

  cpc_pkg::sqrt_side_t          sq_side_in, sq_side_out;
  logic                         sq_valid;
  logic [cpc_pkg::ROOT_W-1:0]   root;

  assign sq_side_in = '{pt: pt3_q, s: s3_q, num_x: nx3_q, num_y: ny3_q};

  cpc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .s_i     (s3_q),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side_out)
  );

  cpc_pkg::div_side_t           dv_side_in, dv_side_out;
  logic                         dv_valid;
  logic [cpc_pkg::QUO_W-1:0]    quo_x, quo_y;

  assign dv_side_in = '{pt: sq_side_out.pt, s: sq_side_out.s};

  cpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .root_i  (root),
    .num_x_i (sq_side_out.num_x),
    .num_y_i (sq_side_out.num_y),
    .side_i  (dv_side_in),
    .valid_o (dv_valid),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .side_o  (dv_side_out)
  );

  // Candidate forming.
  coord_t  px, py, pz, qsx, qsy;
  logic    on_axis, outside;
  cand_t   cand_d;

  assign px      = dv_side_out.pt.point_x;
  assign py      = dv_side_out.pt.point_y;
  assign pz      = dv_side_out.pt.point_z;
  assign on_axis = dv_side_out.s == '0;
  assign outside = dv_side_out.s > rad_sq_q;
  assign qsx     = apply_sign(px < 0, quo_x);
  assign qsy     = apply_sign(py < 0, quo_y);

  always_comb begin
    cand_d.sx = on_axis ? coord_t'(cyl_radius_q) : qsx;
    cand_d.sy = on_axis ? '0 : qsy;
    if (pz < -half) begin
      cand_d.sz = -half;
    end else if (pz > half) begin
      cand_d.sz = half;
    end else begin
      cand_d.sz = pz;
    end
    cand_d.cx = outside ? qsx : px;
    cand_d.cy = outside ? qsy : py;
    cand_d.hz = half;
  end

  logic             c1_v_q, c2_v_q, c3_v_q, c4_v_q;
  cand_t            c1_q, c2_q, c3_q, c4_q;
  cpc_pkg::point_t  cp1_q;
  mag_t             m_sx_q, m_sy_q, m_sz_q, m_cx_q, m_cy_q, m_tz_q, m_bz_q;
  sq_t              q_sx_q, q_sy_q, q_sz_q, q_cx_q, q_cy_q, q_tz_q, q_bz_q;
  dist_t            d_side_q, d_top_q, d_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
      c4_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      c1_v_q <= dv_valid;
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
      c4_v_q <= c3_v_q;
      done_o <= c4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q     <= cand_d;
    cp1_q    <= dv_side_out.pt;
    c2_q     <= c1_q;
    m_sx_q   <= mag_of(diff_t'(cp1_q.point_x) - diff_t'(c1_q.sx));
    m_sy_q   <= mag_of(diff_t'(cp1_q.point_y) - diff_t'(c1_q.sy));
    m_sz_q   <= mag_of(diff_t'(cp1_q.point_z) - diff_t'(c1_q.sz));
    m_cx_q   <= mag_of(diff_t'(cp1_q.point_x) - diff_t'(c1_q.cx));
    m_cy_q   <= mag_of(diff_t'(cp1_q.point_y) - diff_t'(c1_q.cy));
    m_tz_q   <= mag_of(diff_t'(cp1_q.point_z) - diff_t'(c1_q.hz));
    m_bz_q   <= mag_of(diff_t'(cp1_q.point_z) + diff_t'(c1_q.hz));
    c3_q     <= c2_q;
    q_sx_q   <= sq_t'(m_sx_q) * sq_t'(m_sx_q);
    q_sy_q   <= sq_t'(m_sy_q) * sq_t'(m_sy_q);
    q_sz_q   <= sq_t'(m_sz_q) * sq_t'(m_sz_q);
    q_cx_q   <= sq_t'(m_cx_q) * sq_t'(m_cx_q);
    q_cy_q   <= sq_t'(m_cy_q) * sq_t'(m_cy_q);
    q_tz_q   <= sq_t'(m_tz_q) * sq_t'(m_tz_q);
    q_bz_q   <= sq_t'(m_bz_q) * sq_t'(m_bz_q);
    c4_q     <= c3_q;
    d_side_q <= dist_t'(q_sx_q) + dist_t'(q_sy_q) + dist_t'(q_sz_q);
    d_top_q  <= dist_t'(q_cx_q) + dist_t'(q_cy_q) + dist_t'(q_tz_q);
    d_bot_q  <= dist_t'(q_cx_q) + dist_t'(q_cy_q) + dist_t'(q_bz_q);
  end

  cpc_pkg::proj_t res_d;

  always_comb begin
    if (d_side_q <= d_top_q && d_side_q <= d_bot_q) begin
      res_d = '{proj_x: c4_q.sx, proj_y: c4_q.sy, proj_z: c4_q.sz,
                surface: cpc_pkg::SURF_SIDE};
    end else if (d_top_q <= d_bot_q) begin
      res_d = '{proj_x: c4_q.cx, proj_y: c4_q.cy, proj_z: c4_q.hz,
                surface: cpc_pkg::SURF_TOP};
    end else begin
      res_d = '{proj_x: c4_q.cx, proj_y: c4_q.cy, proj_z: -c4_q.hz,
                surface: cpc_pkg::SURF_BOTTOM};
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

  assign busy_o = 1'b0;

endmodule

[rtl/cpc_checker.sv]
// Port-level checks for the closest point on cylinder unit, bound to its top level.
// Depends on cpc_pkg and closest_point_on_cylinder_unit.

module cpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input cpc_pkg::proj_t                 result_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  a_word_comes_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(cpc_pkg::LATENCY) done_o)
    else $error("accepted word produced no result");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, cpc_pkg::LATENCY))
    else $error("result without an accepted word");

  a_top_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.surface == cpc_pkg::SURF_TOP |-> !result_o.proj_z[cpc_pkg::COORD_W-1])
    else $error("top cap result below the midplane");

  a_bottom_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.surface == cpc_pkg::SURF_BOTTOM |->
      result_o.proj_z[cpc_pkg::COORD_W-1] || result_o.proj_z == '0)
    else $error("bottom cap result above the midplane");

endmodule

bind closest_point_on_cylinder_unit cpc_checker u_cpc_checker (.*);
